// ===== src/periodic_timer_bank_macros.svh =====
// ----------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Shared assertion shorthands for the timer bank checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while in reset.
`define PTB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while in reset.
`define PTB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Field widths, command and result codes, and default parameter values.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int MS_PER_TICK_DEF = 10;

    localparam int CMD_W     = 2;
    localparam int PERIOD_W  = 28;
    localparam int OWNER_W   = 7;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 4;
    localparam int REMOVED_W = 5;

    localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_CREATE  = 2'd1,
        CMD_DESTROY = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATED   = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_DESTROYED = 3'd2,
        KIND_EXPIRED   = 3'd3,
        KIND_TICK_DONE = 3'd4
    } kind_t;

    // Write enables of the slot store, one per field.
    typedef struct packed {
        logic rem;
        logic rld;
        logic own;
    } store_we_t;

endpackage

// ===== src/ptb_alu.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank subtractor
// Shared subtract unit for the per-slot count decrements.
// ----------------------------------------------------------------------------
module ptb_alu #(
    parameter int WIDTH = ptb_pkg::COUNT_BITS_DEF
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff
);

    assign diff = a - b;

endmodule

// ===== src/ptb_store.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank slot store
// Remaining count, reload count and owner tag per slot, registered read.
// ----------------------------------------------------------------------------
module ptb_store #(
    parameter int NUM_SLOTS  = ptb_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = ptb_pkg::COUNT_BITS_DEF,
    parameter int ADDR_BITS  = 4
) (
    input  logic                               clk,
    input  ptb_pkg::store_we_t                 we,
    input  logic [ADDR_BITS-1:0]               waddr,
    input  logic [COUNT_BITS-1:0]              wr_rem,
    input  logic [COUNT_BITS-1:0]              wr_rld,
    input  logic signed [ptb_pkg::OWNER_W-1:0] wr_own,
    input  logic                               rd_en,
    input  logic [ADDR_BITS-1:0]               raddr,
    output logic [COUNT_BITS-1:0]              rd_rem,
    output logic [COUNT_BITS-1:0]              rd_rld,
    output logic signed [ptb_pkg::OWNER_W-1:0] rd_own
);

    logic [COUNT_BITS-1:0]              rem_mem [NUM_SLOTS];
    logic [COUNT_BITS-1:0]              rld_mem [NUM_SLOTS];
    logic signed [ptb_pkg::OWNER_W-1:0] own_mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we.rem)
        begin
            rem_mem[waddr] <= wr_rem;
        end
        if (we.rld)
        begin
            rld_mem[waddr] <= wr_rld;
        end
        if (we.own)
        begin
            own_mem[waddr] <= wr_own;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_rem <= rem_mem[raddr];
            rd_rld <= rld_mem[raddr];
            rd_own <= own_mem[raddr];
        end
    end

endmodule

// ===== src/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank
// Sequencer that walks the slots one per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
// Tick and destroy: every slot is walked before the last word is shown; expiry
// words stream out one per cycle during the walk, set by the one store read port.
// Create: ends when the search for the lowest free slot finds one or runs out.
// Busy falls in the cycle the last word is shown; the next command is taken at
// the edge that ends that cycle.
// Reset clears the active bits at once; there is no clearing pass.
module periodic_timer_bank #(
    parameter int NUM_SLOTS   = ptb_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS  = ptb_pkg::COUNT_BITS_DEF,
    parameter int MS_PER_TICK = ptb_pkg::MS_PER_TICK_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ptb_pkg::CMD_W-1:0]            cmd,
    input  logic [ptb_pkg::PERIOD_W-1:0]         period_ms,
    input  logic signed [ptb_pkg::OWNER_W-1:0]   owner_id,
    output logic                                 valid,
    output logic [ptb_pkg::KIND_W-1:0]           kind,
    output logic [ptb_pkg::SLOT_W-1:0]           slot,
    output logic signed [ptb_pkg::OWNER_W-1:0]   owner,
    output logic [ptb_pkg::REMOVED_W-1:0]        removed_count,
    output logic                                 last
);

    localparam int PW    = ptb_pkg::PERIOD_W;
    localparam int SB    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int EW    = (COUNT_BITS > PW) ? COUNT_BITS : PW;
    localparam int RW    = PW + 1;
    localparam int PRODW = PW + RW;
    localparam int SHIFT = PW + $clog2(MS_PER_TICK);

    localparam logic [CW-1:0]         SLOT_END = CW'(NUM_SLOTS);
    localparam logic [COUNT_BITS-1:0] DEC_STEP = COUNT_BITS'(1);
    localparam logic [RW-1:0]         RECIP    =
        RW'(((64'd1 << SHIFT) / 64'(MS_PER_TICK)) + 64'd1);
    localparam logic [EW-1:0]         CNT_MAX  = EW'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_TICK    = 4'b0010,
        ST_CREATE  = 4'b0100,
        ST_DESTROY = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [CW-1:0]                      cnt_reg, cnt_next;
    logic                               pend_reg, pend_next;
    logic [SB-1:0]                      pend_idx_reg, pend_idx_next;
    logic [NUM_SLOTS-1:0]               active_reg, active_next;
    logic signed [ptb_pkg::OWNER_W-1:0] req_owner_reg, req_owner_next;
    logic [ptb_pkg::REMOVED_W-1:0]      freed_reg, freed_next;
    logic                               found_reg, found_next;
    logic [SB-1:0]                      free_idx_reg, free_idx_next;
    logic [PW-1:0]                      dq_reg, dq_next;

    logic                               valid_reg, valid_next;
    ptb_pkg::kind_t                     kind_reg, kind_next;
    logic [ptb_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic signed [ptb_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic [ptb_pkg::REMOVED_W-1:0]      removed_reg, removed_next;
    logic                               last_reg, last_next;

    ptb_pkg::store_we_t                 st_we;
    logic [SB-1:0]                      st_waddr;
    logic [COUNT_BITS-1:0]              st_wr_rem;
    logic                               st_rd_en;
    logic [COUNT_BITS-1:0]              rd_rem;
    logic [COUNT_BITS-1:0]              rd_rld;
    logic signed [ptb_pkg::OWNER_W-1:0] rd_own;

    logic [COUNT_BITS-1:0]              dec;
    logic [PRODW-1:0]                   prod, quot_full;
    logic [EW-1:0]                      quot_ext, ticks_ext;
    logic [COUNT_BITS-1:0]              ticks;

    ptb_alu #(
        .WIDTH (COUNT_BITS)
    ) u_alu (
        .a    (rd_rem),
        .b    (DEC_STEP),
        .diff (dec)
    );

    ptb_store #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .ADDR_BITS  (SB)
    ) u_store (
        .clk    (clk),
        .we     (st_we),
        .waddr  (st_waddr),
        .wr_rem (st_wr_rem),
        .wr_rld (ticks),
        .wr_own (req_owner_reg),
        .rd_en  (st_rd_en),
        .raddr  (cnt_reg[SB-1:0]),
        .rd_rem (rd_rem),
        .rd_rld (rd_rld),
        .rd_own (rd_own)
    );

    // The period is scaled to ticks by a 28 by 29 bit constant multiply with a
    // rounded-up reciprocal; the rounding error stays below one quotient step
    // for every 28-bit period, so the shifted product is the exact quotient.
    assign prod      = PRODW'(period_ms) * PRODW'(RECIP);
    assign quot_full = prod >> SHIFT;

    // Short periods become one tick; long ones saturate at the counter maximum.
    assign quot_ext  = EW'(dq_reg);
    assign ticks_ext = (dq_reg == '0) ? EW'(1) :
                       (quot_ext > CNT_MAX) ? CNT_MAX : quot_ext;
    assign ticks     = ticks_ext[COUNT_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        active_next    = active_reg;
        req_owner_next = req_owner_reg;
        freed_next     = freed_reg;
        found_next     = found_reg;
        free_idx_next  = free_idx_reg;
        dq_next        = dq_reg;

        valid_next     = 1'b0;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        owner_next     = owner_reg;
        removed_next   = removed_reg;
        last_next      = last_reg;

        st_we          = '0;
        st_waddr       = pend_idx_reg;
        st_wr_rem      = dec;
        st_rd_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next       = '0;
                    pend_next      = 1'b0;
                    freed_next     = '0;
                    found_next     = 1'b0;
                    req_owner_next = owner_id;
                    dq_next        = quot_full[PW-1:0];
                    unique case (ptb_pkg::cmd_t'(cmd))
                        ptb_pkg::CMD_TICK:    state_next = ST_TICK;
                        ptb_pkg::CMD_CREATE:  state_next = ST_CREATE;
                        ptb_pkg::CMD_DESTROY: state_next = ST_DESTROY;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TICK, ST_DESTROY:
            begin
                // Read slot cnt while slot pend_idx, read last cycle, is processed.
                if (cnt_reg != SLOT_END)
                begin
                    st_rd_en      = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[SB-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && active_reg[pend_idx_reg])
                begin
                    if (state_reg == ST_TICK)
                    begin
                        st_we.rem = 1'b1;
                        if (dec == '0)
                        begin
                            st_wr_rem    = rd_rld;
                            valid_next   = 1'b1;
                            kind_next    = ptb_pkg::KIND_EXPIRED;
                            slot_next    = ptb_pkg::SLOT_W'(pend_idx_reg);
                            owner_next   = rd_own;
                            removed_next = '0;
                            last_next    = 1'b0;
                        end
                    end
                    else if (rd_own == req_owner_reg)
                    begin
                        active_next[pend_idx_reg] = 1'b0;
                        if (freed_reg != ptb_pkg::REMOVED_MAX)
                        begin
                            freed_next = freed_reg + 1'b1;
                        end
                    end
                end

                if (cnt_reg == SLOT_END && !pend_reg)
                begin
                    valid_next   = 1'b1;
                    kind_next    = (state_reg == ST_TICK) ? ptb_pkg::KIND_TICK_DONE
                                                          : ptb_pkg::KIND_DESTROYED;
                    slot_next    = '0;
                    owner_next   = '0;
                    removed_next = (state_reg == ST_TICK) ? '0 : freed_reg;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_CREATE:
            begin
                // The free slot search looks at one slot per cycle.
                if (!found_reg && cnt_reg != SLOT_END)
                begin
                    if (!active_reg[cnt_reg[SB-1:0]])
                    begin
                        found_next    = 1'b1;
                        free_idx_next = cnt_reg[SB-1:0];
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end

                if (found_reg || cnt_reg == SLOT_END)
                begin
                    valid_next   = 1'b1;
                    owner_next   = req_owner_reg;
                    removed_next = '0;
                    last_next    = 1'b1;
                    state_next   = ST_IDLE;
                    if (found_reg)
                    begin
                        st_we                     = '1;
                        st_waddr                  = free_idx_reg;
                        st_wr_rem                 = ticks;
                        active_next[free_idx_reg] = 1'b1;
                        kind_next                 = ptb_pkg::KIND_CREATED;
                        slot_next                 = ptb_pkg::SLOT_W'(free_idx_reg);
                    end
                    else
                    begin
                        kind_next = ptb_pkg::KIND_FULL;
                        slot_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            active_reg <= '0;
            freed_reg  <= '0;
            found_reg  <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            active_reg <= active_next;
            freed_reg  <= freed_next;
            found_reg  <= found_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        req_owner_reg <= req_owner_next;
        free_idx_reg  <= free_idx_next;
        dq_reg        <= dq_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        owner_reg     <= owner_next;
        removed_reg   <= removed_next;
        last_reg      <= last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign valid         = valid_reg;
    assign kind          = kind_reg;
    assign slot          = slot_reg;
    assign owner         = owner_reg;
    assign removed_count = removed_reg;
    assign last          = last_reg;

endmodule

// ===== src/ptb_checker.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank checker
// Port-level assertions on command acceptance and result word ordering.
// ----------------------------------------------------------------------------
`include "periodic_timer_bank_macros.svh"

module ptb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               valid,
    input logic [ptb_pkg::KIND_W-1:0]         kind,
    input logic [ptb_pkg::SLOT_W-1:0]         slot,
    input logic signed [ptb_pkg::OWNER_W-1:0] owner,
    input logic                               last
);

    logic expiry_word;
    logic done_word;

    assign expiry_word = valid && (kind == ptb_pkg::KIND_EXPIRED);
    assign done_word   = valid && (kind == ptb_pkg::KIND_TICK_DONE);

    // No command produces a word in the cycle right after it is taken.
    `PTB_ASSERT_NEXT(a_no_word_after_accept, start && !busy, !valid, "word right after accept")

    // The final word of a command is never followed at once by another word.
    `PTB_ASSERT_NEXT(a_last_ends_burst, valid && last, !valid, "word right after last word")

    // Expiry words come out only in the middle of a tick walk.
    `PTB_ASSERT_IMP(a_expiry_in_walk, expiry_word, busy && !last, "expiry word outside walk")

    // The closing tick word carries no slot or owner.
    `PTB_ASSERT_IMP(a_done_clean, done_word, last && slot == '0 && owner == '0, "bad tick-done word")

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);
